### sv/tce_pkg.sv
// ============================================================================
// tce_pkg : text console engine shared definitions
// Item and result structs, opcodes, datapath command and status types.
// ============================================================================
package tce_pkg;

    localparam int ROWS_DEF     = 25;
    localparam int COLS_DEF     = 80;
    localparam int MAX_READ_DEF = 64;

    localparam int ROW_W = 5;
    localparam int COL_W = 7;

    localparam logic [2:0] OP_WRITE     = 3'd0;
    localparam logic [2:0] OP_READ      = 3'd1;
    localparam logic [2:0] OP_SEEK      = 3'd2;
    localparam logic [2:0] OP_SCROLL_UP = 3'd3;
    localparam logic [2:0] OP_SCROLL_DN = 3'd4;
    localparam logic [2:0] OP_CLEAR     = 3'd5;

    localparam logic [7:0]  CH_LF      = 8'd10;
    localparam logic [7:0]  CH_CR      = 8'd13;
    localparam logic [7:0]  CH_SPACE   = 8'h20;
    localparam logic [7:0]  RESET_ATTR = 8'h0F;
    localparam logic [15:0] HIDDEN_LOC = 16'hFFFF;

    localparam logic [1:0] CFG_ATTR    = 2'd0;
    localparam logic [1:0] CFG_SCROLL  = 2'd1;
    localparam logic [1:0] CFG_VISIBLE = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  char_code;
        logic [10:0] position;
        logic [4:0]  scroll_rows;
        logic [6:0]  read_count;
    } t_item;

    typedef struct packed {
        logic        status;
        logic [7:0]  read_char;
        logic        read_valid;
        logic        last;
        logic [15:0] cursor_location;
    } t_result;

    typedef enum logic [4:0] {
        DC_NONE,
        DC_LATCH,
        DC_NL,
        DC_WR_CELL,
        DC_ROW_FIX,
        DC_SCRL_SHIFT,
        DC_SCRL_PTRS,
        DC_COPY_WR,
        DC_FILL_START,
        DC_FILL,
        DC_FILL_INIT,
        DC_CLEAR_SETUP,
        DC_SEEK_BAD,
        DC_SEEK_STEP,
        DC_SEEK_SET,
        DC_RD_SETUP,
        DC_RD_OUT,
        DC_RES
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   one_line;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] opcode;
        logic       is_nl;
        logic       col_full;
        logic       need_scroll;
        logic       copy_done;
        logic       fill_done;
        logic       seek_bad;
        logic       seek_more;
        logic       rd_empty;
        logic       rd_last;
    } t_dp_stat;

    typedef enum logic [4:0] {
        S_INIT_SETUP,
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_WR,
        S_NL_CHK,
        S_WR_CELL,
        S_SC_SHIFT,
        S_SC_PTRS,
        S_COPY_RD,
        S_COPY_WR,
        S_FILL,
        S_ROWFIX,
        S_CLR,
        S_SEEK,
        S_RD_SETUP,
        S_RD_CHK,
        S_RD_ISSUE,
        S_RD_OUT,
        S_RES
    } t_state;

endpackage

### sv/tce_ctrl.sv
// ============================================================================
// tce_ctrl : text console controller
// Sequences each item through the datapath one command per cycle.
// ============================================================================
module tce_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  tce_pkg::t_dp_stat i_stat,
    output tce_pkg::t_dp_cmd  o_cmd
);
    import tce_pkg::*;

    t_state r_state, n_state;
    logic   r_from_wr, n_from_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT_SETUP;
            r_from_wr <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_from_wr <= n_from_wr;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_from_wr = r_from_wr;
        unique case (r_state)
            S_INIT_SETUP: n_state = S_INIT;
            S_INIT:       if (i_stat.fill_done) n_state = S_IDLE;
            S_IDLE:       if (i_start) n_state = S_DISPATCH;
            S_DISPATCH: begin
                unique case (i_stat.opcode) inside
                    OP_WRITE:                   n_state = S_WR;
                    OP_READ:                    n_state = S_RD_SETUP;
                    OP_SEEK:                    n_state = S_SEEK;
                    OP_SCROLL_UP, OP_SCROLL_DN: n_state = S_SC_SHIFT;
                    OP_CLEAR:                   n_state = S_CLR;
                    default:                    n_state = S_RES;
                endcase
            end
            S_WR: begin
                if (i_stat.is_nl || i_stat.col_full) n_state = S_NL_CHK;
                else n_state = S_WR_CELL;
            end
            S_NL_CHK: begin
                if (i_stat.need_scroll) begin
                    n_state   = S_SC_SHIFT;
                    n_from_wr = 1'b1;
                end else if (i_stat.is_nl) begin
                    n_state = S_RES;
                end else begin
                    n_state = S_WR_CELL;
                end
            end
            S_WR_CELL:  n_state = S_RES;
            S_SC_SHIFT: n_state = S_SC_PTRS;
            S_SC_PTRS:  n_state = S_COPY_RD;
            S_COPY_RD:  n_state = i_stat.copy_done ? S_FILL : S_COPY_WR;
            S_COPY_WR:  n_state = S_COPY_RD;
            S_FILL: begin
                if (i_stat.fill_done) n_state = r_from_wr ? S_ROWFIX : S_RES;
            end
            S_ROWFIX: begin
                n_from_wr = 1'b0;
                n_state   = i_stat.is_nl ? S_RES : S_WR_CELL;
            end
            S_CLR: n_state = S_FILL;
            S_SEEK: begin
                if (i_stat.seek_bad || !i_stat.seek_more) n_state = S_RES;
            end
            S_RD_SETUP: n_state = S_RD_CHK;
            S_RD_CHK:   n_state = i_stat.rd_empty ? S_RES : S_RD_ISSUE;
            S_RD_ISSUE: n_state = S_RD_OUT;
            S_RD_OUT:   n_state = i_stat.rd_last ? S_IDLE : S_RD_ISSUE;
            S_RES:      n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op       = DC_NONE;
        o_cmd.one_line = r_from_wr;
        unique case (r_state)
            S_INIT_SETUP: o_cmd.op = DC_CLEAR_SETUP;
            S_INIT:       if (!i_stat.fill_done) o_cmd.op = DC_FILL_INIT;
            S_IDLE:       if (i_start) o_cmd.op = DC_LATCH;
            S_WR:         if (i_stat.is_nl || i_stat.col_full) o_cmd.op = DC_NL;
            S_WR_CELL:    o_cmd.op = DC_WR_CELL;
            S_SC_SHIFT:   o_cmd.op = DC_SCRL_SHIFT;
            S_SC_PTRS:    o_cmd.op = DC_SCRL_PTRS;
            S_COPY_RD:    if (i_stat.copy_done) o_cmd.op = DC_FILL_START;
            S_COPY_WR:    o_cmd.op = DC_COPY_WR;
            S_FILL:       if (!i_stat.fill_done) o_cmd.op = DC_FILL;
            S_ROWFIX:     o_cmd.op = DC_ROW_FIX;
            S_CLR:        o_cmd.op = DC_CLEAR_SETUP;
            S_SEEK: begin
                if (i_stat.seek_bad)       o_cmd.op = DC_SEEK_BAD;
                else if (i_stat.seek_more) o_cmd.op = DC_SEEK_STEP;
                else                       o_cmd.op = DC_SEEK_SET;
            end
            S_RD_SETUP:   o_cmd.op = DC_RD_SETUP;
            S_RD_OUT:     o_cmd.op = DC_RD_OUT;
            S_RES:        o_cmd.op = DC_RES;
            default:      o_cmd.op = DC_NONE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### sv/tce_datapath.sv
// ============================================================================
// tce_datapath : text console datapath
// Screen memory, cursor, copy/fill pointers, seek divider and result register.
// ============================================================================
module tce_datapath #(
    parameter int ROWS     = tce_pkg::ROWS_DEF,
    parameter int COLS     = tce_pkg::COLS_DEF,
    parameter int MAX_READ = tce_pkg::MAX_READ_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tce_pkg::t_item    i_item,
    input  tce_pkg::t_dp_cmd  i_cmd,
    output tce_pkg::t_dp_stat o_stat,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    output logic              o_strobe,
    output tce_pkg::t_result  o_result
);
    import tce_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS + COLS + 1);
    localparam int IW    = $clog2(CELLS);
    localparam logic [AW-1:0] CELLS_A = AW'(CELLS);

    logic [15:0] mem [CELLS];

    // configuration
    logic [7:0] r_attr;
    logic       r_autoscroll;
    logic       r_visible;

    // cursor
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;

    // latched item
    logic [2:0]  r_op;
    logic [7:0]  r_ch;
    logic [10:0] r_pos;
    logic [4:0]  r_rows;
    logic [6:0]  r_cnt;

    // work registers
    logic [AW-1:0]    r_dst, r_src, r_shift;
    logic             r_down;
    logic [10:0]      r_rem;
    logic [ROW_W-1:0] r_srow;
    logic [6:0]       r_n;
    logic             r_status;
    logic [15:0]      r_rdata;
    logic             r_strobe;
    t_result          r_res;

    logic [AW-1:0] w_lin;
    logic [4:0]    w_amt;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [15:0]   w_wdata;
    logic [AW-1:0] w_fill_lim;

    assign w_lin = AW'(r_row * COLS + r_col);
    assign w_amt = i_cmd.one_line ? 5'd1 : ((r_rows > 5'(ROWS)) ? 5'(ROWS) : r_rows);
    assign w_fill_lim = r_down ? r_shift : CELLS_A;

    assign o_stat.opcode      = r_op;
    assign o_stat.is_nl       = (r_ch == CH_LF) || (r_ch == CH_CR);
    assign o_stat.col_full    = (r_col >= COL_W'(COLS));
    assign o_stat.need_scroll = r_autoscroll && (r_row >= ROW_W'(ROWS));
    assign o_stat.copy_done   = r_down ? ((r_dst < r_shift) || (r_dst >= CELLS_A))
                                       : (r_src >= CELLS_A);
    assign o_stat.fill_done   = (r_dst == w_fill_lim);
    assign o_stat.seek_bad    = ({5'b0, r_pos} >= 16'(CELLS));
    assign o_stat.seek_more   = (r_rem >= 11'(COLS));
    assign o_stat.rd_empty    = (r_cnt == 7'd0) || (r_src >= CELLS_A);
    assign o_stat.rd_last     = ((r_n + 7'd1) == r_cnt) || ((r_src + AW'(1)) == CELLS_A);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_dst;
        w_wdata = {r_attr, CH_SPACE};
        case (i_cmd.op)
            DC_COPY_WR: begin
                w_we    = 1'b1;
                w_wdata = r_rdata;
            end
            DC_FILL: w_we = 1'b1;
            DC_FILL_INIT: begin
                w_we    = 1'b1;
                w_wdata = {RESET_ATTR, CH_SPACE};
            end
            DC_WR_CELL: begin
                w_we    = (r_row < ROW_W'(ROWS)) && (r_col < COL_W'(COLS));
                w_waddr = w_lin;
                w_wdata = {r_attr, r_ch};
            end
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr[IW-1:0]] <= w_wdata;
        r_rdata <= mem[r_src[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr       <= RESET_ATTR;
            r_autoscroll <= 1'b0;
            r_visible    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ATTR:    r_attr       <= i_cfg_data;
                CFG_SCROLL:  r_autoscroll <= i_cfg_data[0];
                CFG_VISIBLE: r_visible    <= i_cfg_data[0];
                default:     r_attr       <= r_attr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_col    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.op == DC_RES) || (i_cmd.op == DC_RD_OUT);
            case (i_cmd.op)
                DC_NL: begin
                    r_col <= '0;
                    if (r_row < ROW_W'(ROWS)) r_row <= r_row + ROW_W'(1);
                end
                DC_WR_CELL: if (r_col < COL_W'(COLS)) r_col <= r_col + COL_W'(1);
                DC_ROW_FIX: r_row <= ROW_W'(ROWS - 1);
                DC_CLEAR_SETUP: begin
                    r_row <= '0;
                    r_col <= '0;
                end
                DC_SEEK_SET: begin
                    r_row <= r_srow;
                    r_col <= COL_W'(r_rem);
                end
                default: r_row <= r_row;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op) inside
            DC_LATCH: begin
                r_op     <= i_item.opcode;
                r_ch     <= i_item.char_code;
                r_pos    <= i_item.position;
                r_rows   <= i_item.scroll_rows;
                r_cnt    <= (i_item.read_count > 7'(MAX_READ)) ? 7'(MAX_READ)
                                                               : i_item.read_count;
                r_rem    <= i_item.position;
                r_srow   <= '0;
                r_status <= 1'b0;
            end
            DC_SCRL_SHIFT: begin
                r_shift <= AW'(w_amt * COLS);
                r_down  <= !i_cmd.one_line && (r_op == OP_SCROLL_DN);
            end
            DC_SCRL_PTRS: begin
                if (r_down) begin
                    r_dst <= CELLS_A - AW'(1);
                    r_src <= CELLS_A - AW'(1) - r_shift;
                end else begin
                    r_dst <= '0;
                    r_src <= r_shift;
                end
            end
            DC_COPY_WR: begin
                if (r_down) begin
                    r_dst <= r_dst - AW'(1);
                    r_src <= r_src - AW'(1);
                end else begin
                    r_dst <= r_dst + AW'(1);
                    r_src <= r_src + AW'(1);
                end
            end
            DC_FILL_START: if (r_down) r_dst <= '0;
            DC_FILL, DC_FILL_INIT: r_dst <= r_dst + AW'(1);
            DC_CLEAR_SETUP: begin
                r_dst  <= '0;
                r_down <= 1'b0;
            end
            DC_SEEK_BAD: r_status <= 1'b1;
            DC_SEEK_STEP: begin
                r_rem  <= r_rem - 11'(COLS);
                r_srow <= r_srow + ROW_W'(1);
            end
            DC_RD_SETUP: begin
                r_src <= w_lin;
                r_n   <= '0;
            end
            DC_RD_OUT: begin
                r_src <= r_src + AW'(1);
                r_n   <= r_n + 7'd1;
            end
            default: r_n <= r_n;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res.cursor_location <= r_visible ? 16'(w_lin) : HIDDEN_LOC;
        if (i_cmd.op == DC_RD_OUT) begin
            r_res.status     <= 1'b0;
            r_res.read_char  <= r_rdata[7:0];
            r_res.read_valid <= 1'b1;
            r_res.last       <= o_stat.rd_last;
        end else begin
            r_res.status     <= r_status;
            r_res.read_char  <= 8'd0;
            r_res.read_valid <= 1'b0;
            r_res.last       <= 1'b1;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

### sv/text_console_engine_top.sv
// ============================================================================
// text_console_engine_top : text mode console engine
// ROWS x COLS screen of char/attribute cells with cursor, scroll and clear.
// ============================================================================
// Write: a character that wraps first takes a newline step, plus a scroll pass
//   under autoscroll; seek steps row by row (serial subtract of COLS); read
//   gives one result per char, or one empty result. One item at a time.
// Scroll and clear: a read and a write state per moved cell, a fill step per
//   blanked cell; set by the single write and read port of the screen memory.
// Reset: synchronous; clears all ROWS*COLS cells with busy high; no stalls.
module text_console_engine_top #(
    parameter int ROWS     = tce_pkg::ROWS_DEF,
    parameter int COLS     = tce_pkg::COLS_DEF,
    parameter int MAX_READ = tce_pkg::MAX_READ_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // item channel
    input  logic             start,
    output logic             busy,
    input  tce_pkg::t_item   i_item,
    // result channel: each result shown for a single cycle, marked by strobe; a read gives one per char
    output logic             o_strobe,
    output tce_pkg::t_result o_result,
    // configuration writes
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [7:0]       i_cfg_data
);
    import tce_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // registers are always writable; host writes only while idle
    assign o_cfg_ready = 1'b1;

    tce_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    tce_datapath #(
        .ROWS     (ROWS),
        .COLS     (COLS),
        .MAX_READ (MAX_READ)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule

### tb/text_console_engine_top_test.sv
// ============================================================================
// text_console_engine_top_test : self-checking bench for the console engine
// Drives write, read, seek, scroll, clear and unknown opcodes under several
// attribute/autoscroll/visibility settings. A cycle-free screen predictor
// computes every expected result item; the monitor checks each strobed result
// field by field in order.
// ============================================================================
module text_console_engine_top_test;
    import tce_pkg::*;

    localparam int ROWS  = ROWS_DEF;
    localparam int COLS  = COLS_DEF;
    localparam int CELLS = ROWS * COLS;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    t_item   i_item = '0;
    logic    o_strobe;
    t_result o_result;
    logic    i_cfg_valid = 1'b0;
    logic    o_cfg_ready;
    logic [1:0] i_cfg_index = CFG_ATTR;
    logic [7:0] i_cfg_data = '0;

    text_console_engine_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .start(start), .busy(busy), .i_item(i_item),
        .o_strobe(o_strobe), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Screen predictor: own copy of cells, cursor and register settings
    // ------------------------------------------------------------------
    logic [15:0] scr [CELLS];
    int          cur_row, cur_col;
    logic [7:0]  attr_reg;
    logic        autoscroll_reg, visible_reg;
    t_result     result_q[$];   // expected result items, oldest first

    function logic [15:0] blank();
        return {attr_reg, CH_SPACE};
    endfunction

    function void shift_up(int amt);
        int sh;
        if (amt > ROWS) amt = ROWS;
        sh = amt * COLS;
        for (int i = 0; i + sh < CELLS; i++) scr[i] = scr[i + sh];
        for (int i = CELLS - sh; i < CELLS; i++) scr[i] = blank();
    endfunction

    function void shift_down(int amt);
        int sh;
        if (amt > ROWS) amt = ROWS;
        sh = amt * COLS;
        for (int i = CELLS; i > sh; i--) scr[i-1] = scr[i-1-sh];
        for (int i = 0; i < sh; i++) scr[i] = blank();
    endfunction

    function void line_feed();
        cur_col = 0;
        if (cur_row < ROWS) cur_row++;
        if (autoscroll_reg && cur_row >= ROWS) begin
            shift_up(1);
            cur_row = ROWS - 1;
        end
    endfunction

    function void push_result(logic st, logic [7:0] ch, logic vld, logic lst);
        t_result r;
        r.status          = st;
        r.read_char       = ch;
        r.read_valid      = vld;
        r.last            = lst;
        r.cursor_location = visible_reg ? 16'(cur_row * COLS + cur_col) : HIDDEN_LOC;
        result_q.push_back(r);
    endfunction

    function void predict_console(t_item it);
        int  loc, cnt, n;
        logic st;
        st = 1'b0;
        case (it.opcode)
            OP_WRITE: begin
                if (it.char_code == CH_LF || it.char_code == CH_CR) begin
                    line_feed();
                end else begin
                    // lazy wrap: the pending column moves down only now
                    if (cur_col >= COLS) line_feed();
                    if (cur_row < ROWS && cur_col < COLS)
                        scr[cur_row * COLS + cur_col] = {attr_reg, it.char_code};
                    if (cur_col < COLS) cur_col++;
                end
            end
            OP_READ: begin
                loc = cur_row * COLS + cur_col;
                cnt = (it.read_count > MAX_READ_DEF) ? MAX_READ_DEF : it.read_count;
                n = 0;
                while (n < cnt && loc < CELLS) begin
                    push_result(1'b0, scr[loc][7:0], 1'b1, 1'b0);
                    loc++;
                    n++;
                end
                if (n == 0) push_result(1'b0, 8'h00, 1'b0, 1'b1);
                else result_q[result_q.size()-1].last = 1'b1;
                return;
            end
            OP_SEEK: begin
                if (it.position < CELLS) begin
                    cur_row = it.position / COLS;
                    cur_col = it.position % COLS;
                end else begin
                    st = 1'b1;
                end
            end
            OP_SCROLL_UP: shift_up(it.scroll_rows);
            OP_SCROLL_DN: shift_down(it.scroll_rows);
            OP_CLEAR: begin
                for (int i = 0; i < CELLS; i++) scr[i] = blank();
                cur_row = 0;
                cur_col = 0;
            end
            default: ;
        endcase
        push_result(st, 8'h00, 1'b0, 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // Driver: pending items, each with a drain flag (wait for all results)
    // ------------------------------------------------------------------
    typedef struct {
        t_item it;
        bit    drain;
    } t_pend;

    t_pend pend_q[$];
    int    gap_cnt = 0;
    bit    no_idle = 0;     // stretches with back-to-back items
    int    n_sent = 0;      // items accepted (driver only)
    int    n_done = 0;      // final result items seen (monitor only)
    int    n_results = 0;
    int    n_reads = 0;
    int    errors = 0;

    function int draw_gap();
        if ($urandom_range(0, 29) == 0) no_idle = !no_idle;
        return no_idle ? 0 : $urandom_range(0, 18);
    endfunction

    always @(posedge i_clk) begin
        if (start && !busy) begin
            // item taken at this edge: predict, then present the next one
            predict_console(i_item);
            n_sent++;
            gap_cnt = draw_gap();
            if (gap_cnt == 0 && pend_q.size() > 0 && !pend_q[0].drain) begin
                i_item <= pend_q.pop_front().it;
            end else begin
                start <= 1'b0;
            end
        end else if (!start && i_rst_n) begin
            if (gap_cnt > 0) begin
                gap_cnt = gap_cnt - 1;
            end else if (pend_q.size() > 0 && (!pend_q[0].drain || n_done == n_sent)) begin
                i_item <= pend_q.pop_front().it;
                start  <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: results cannot be stalled, check each strobed item
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_strobe) begin
            n_results <= n_results + 1;
            if (o_result.last) n_done <= n_done + 1;
            if (result_q.size() == 0) begin
                $error("unexpected result item: %p", o_result);
                errors++;
            end else begin
                e = result_q.pop_front();
                if (o_result.status !== e.status) begin
                    $error("status: expected %0d actual %0d", e.status, o_result.status);
                    errors++;
                end
                if (o_result.read_char !== e.read_char) begin
                    $error("read_char: expected %h actual %h", e.read_char, o_result.read_char);
                    errors++;
                end
                if (o_result.read_valid !== e.read_valid) begin
                    $error("read_valid: expected %0d actual %0d",
                           e.read_valid, o_result.read_valid);
                    errors++;
                end
                if (o_result.last !== e.last) begin
                    $error("last: expected %0d actual %0d", e.last, o_result.last);
                    errors++;
                end
                if (o_result.cursor_location !== e.cursor_location) begin
                    $error("cursor_location: expected %0d actual %0d",
                           e.cursor_location, o_result.cursor_location);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function t_item mk(logic [2:0] op, logic [7:0] ch = 8'h41, int pos = 0,
                       int rows = 1, int cnt = 1);
        t_item it;
        it.opcode      = op;
        it.char_code   = ch;
        it.position    = 11'(pos);
        it.scroll_rows = 5'(rows);
        it.read_count  = 7'(cnt);
        return it;
    endfunction

    function void add(t_item it, bit drain = 0);
        t_pend p;
        p.it    = it;
        p.drain = drain;
        pend_q.push_back(p);
    endfunction

    // Mostly well-formed console traffic: text runs, newlines, seeks near
    // the screen end so wrap and autoscroll fire, plus noise fields.
    function t_item rand_item();
        t_item it;
        int    sel;
        it  = t_item'({$urandom, $urandom});
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            it.opcode = OP_WRITE;
            if ($urandom_range(0, 7) == 0)
                it.char_code = $urandom_range(0, 1) ? CH_LF : CH_CR;
            else if ($urandom_range(0, 3) == 0)
                it.char_code = 8'($urandom_range(0, 255));
            else
                it.char_code = 8'($urandom_range(8'h21, 8'h7E));
        end else if (sel < 55) begin
            it.opcode = OP_READ;
            it.read_count = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                                         : 7'($urandom_range(1, 16));
        end else if (sel < 73) begin
            it.opcode = OP_SEEK;
            case ($urandom_range(0, 3))
                0: it.position = 11'($urandom_range(CELLS - COLS - 3, CELLS - 1));
                1: it.position = 11'($urandom_range(0, 2047));
                default: it.position = 11'($urandom_range(0, CELLS - 1));
            endcase
        end else if (sel < 85) begin
            it.opcode = ($urandom_range(0, 1)) ? OP_SCROLL_UP : OP_SCROLL_DN;
            if ($urandom_range(0, 3) != 0) it.scroll_rows = 5'($urandom_range(0, 3));
        end else if (sel < 88) begin
            it.opcode = OP_CLEAR;
        end else if (sel < 92) begin
            it.opcode = 3'($urandom_range(6, 7));
        end else begin
            // long text run source: seek to a column near the line end
            it.opcode   = OP_SEEK;
            it.position = 11'($urandom_range(0, ROWS - 1) * COLS + COLS - 1);
        end
        return it;
    endfunction

    task automatic cfg_write(logic [1:0] idx, logic [7:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ATTR:    attr_reg = val;
            CFG_SCROLL:  autoscroll_reg = val[0];
            CFG_VISIBLE: visible_reg = val[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain_all();
        wait (pend_q.size() == 0 && !start && n_done == n_sent && result_q.size() == 0);
        repeat (20) @(posedge i_clk);
        wait (!busy);
    endtask

    task automatic set_console(logic [7:0] a, logic scrl, logic vis);
        drain_all();
        cfg_write(CFG_ATTR, a);
        cfg_write(CFG_SCROLL, {7'd0, scrl});
        cfg_write(CFG_VISIBLE, {7'd0, vis});
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < CELLS; i++) scr[i] = {RESET_ATTR, CH_SPACE};
        cur_row = 0;
        cur_col = 0;
        attr_reg = RESET_ATTR;
        autoscroll_reg = 1'b0;
        visible_reg = 1'b1;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes and the corner cases, reset settings
        add(mk(OP_WRITE, 8'h00));
        add(mk(OP_WRITE, 8'hFF));
        add(mk(OP_WRITE, CH_LF));
        add(mk(OP_WRITE, CH_CR));
        add(mk(OP_SEEK, 8'h00, COLS - 1));
        add(mk(OP_WRITE, 8'h5A));
        add(mk(OP_WRITE, 8'h61));            // column at COLS: wraps, then written
        add(mk(OP_SEEK, 8'h00, CELLS - 1));
        add(mk(OP_WRITE, 8'h62));
        add(mk(OP_WRITE, 8'h63));            // wraps off screen: discarded
        add(mk(OP_WRITE, 8'h64));
        add(mk(OP_READ, 8'h00, 0, 0, 5));    // cursor past the end: empty read
        add(mk(OP_SEEK, 8'h00, CELLS));      // bad seek
        add(mk(OP_SEEK, 8'h00, 2047));
        add(mk(OP_SEEK, 8'h00, 0));
        add(mk(OP_READ, 8'h00, 0, 0, 0));    // zero count
        add(mk(OP_READ, 8'h00, 0, 0, 127));  // saturates at the read limit
        add(mk(OP_SEEK, 8'h00, CELLS - 10));
        add(mk(OP_READ, 8'h00, 0, 0, 64));   // stops at the screen end
        add(mk(OP_SCROLL_UP, 8'h00, 0, 0));
        add(mk(OP_SCROLL_UP, 8'h00, 0, 31));
        add(mk(OP_SCROLL_DN, 8'h00, 0, 1), 1);
        add(mk(OP_SCROLL_DN, 8'h00, 0, 31));
        add(mk(OP_CLEAR));
        add(mk(3'd6));
        add(mk(3'd7, 8'hFF, 2047, 31, 127));
        for (int i = 0; i < 80; i++) add(rand_item(), i == 40);

        // autoscroll on, extreme low attribute
        set_console(8'h00, 1'b1, 1'b1);
        add(mk(OP_SEEK, 8'h00, CELLS - 1));
        add(mk(OP_WRITE, 8'h78));
        add(mk(OP_WRITE, 8'h79));            // wraps past last row: scrolls
        add(mk(OP_WRITE, CH_LF));
        for (int i = 0; i < 90; i++) add(rand_item());

        // cursor hidden, extreme high attribute, no autoscroll
        set_console(8'hFF, 1'b0, 1'b0);
        for (int i = 0; i < 90; i++) add(rand_item(), i == 45);

        // random attribute, autoscroll on, hidden cursor
        set_console(8'($urandom_range(1, 254)), 1'b1, 1'b0);
        for (int i = 0; i < 90; i++) add(rand_item());

        drain_all();
        $display("Ran %0d items across four register settings; %0d result items in order.",
                 n_sent, n_results);
        $display("Covered writes with wrap and autoscroll, reads, seeks, scrolls, clears.");
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

### filelist.f
sv/tce_pkg.sv
sv/tce_ctrl.sv
sv/tce_datapath.sv
sv/text_console_engine_top.sv
tb/text_console_engine_top_test.sv
